[rtl/panel_pixel_pack_addresser_top_assert.svh]
// ----------------------------------------------------------------------------
// Pixel pack addresser assertion macros
// Shared assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PANEL_PIXEL_PACK_ADDRESSER_TOP_ASSERT_SVH
`define PANEL_PIXEL_PACK_ADDRESSER_TOP_ASSERT_SVH

// Same-cycle implication.
`define PPA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pixel pack addresser assertion failed");

// Next-cycle implication.
`define PPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pixel pack addresser assertion failed");

`endif

[rtl/ppa_pkg.sv]
// ----------------------------------------------------------------------------
// Pixel pack addresser package
// Widths, register indexes, mode codes and the inter-stage record.
// ----------------------------------------------------------------------------
package ppa_pkg;

    localparam int unsigned SIDE_W     = 13;  // width / height registers
    localparam int unsigned COORD_W    = 14;  // origin plus pixel, signed
    localparam int unsigned CALC_W     = 16;  // signed working width
    localparam int unsigned PIX_W      = 12;
    localparam int unsigned COLOUR_W   = 4;
    localparam int unsigned ADDR_W     = 23;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned PITCH_W    = 12;
    localparam int unsigned SUB_W      = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned MAX_SIDE_DEF = 4096;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION = 3'd5;

    // Panel modes
    localparam logic [1:0] MODE_FLIP    = 2'd0;
    localparam logic [1:0] MODE_QUARTER = 2'd1;
    localparam logic [1:0] MODE_PLANES  = 2'd2;

    // Rotations (bitplane mode)
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;

    // Reset values
    localparam logic [SIDE_W-1:0] RST_WIDTH  = 13'd600;
    localparam logic [SIDE_W-1:0] RST_HEIGHT = 13'd448;

    // Colour codes in bitplane mode
    localparam logic [COLOUR_W-1:0] COLOUR_BLACK = 4'd1;
    localparam logic [COLOUR_W-1:0] COLOUR_RED   = 4'd2;

    // Byte masks
    localparam logic [BYTE_W-1:0] MASK_HI  = 8'hF0;
    localparam logic [BYTE_W-1:0] MASK_LO  = 8'h0F;
    localparam logic [BYTE_W-1:0] MASK_MSB = 8'h80;

    // Mapped pixel, handed from the mapping stage to the address stages
    typedef struct packed {
        logic                valid;
        logic                planes;
        logic [SIDE_W-1:0]   py;
        logic [PITCH_W-1:0]  pitch;
        logic [PITCH_W-1:0]  col;
        logic [SUB_W-1:0]    sub;
        logic [COLOUR_W-1:0] colour;
    } t_map;

endpackage

[rtl/panel_pixel_pack_addresser_top.sv]
// Throughput: one pixel per clock; o_busy stays low, so start is never refused.
// Four register stages: origin add, bounds/mapping, row multiply, column add.
// Reset (synchronous, active low) empties the pipeline and loads the register
// defaults: mode 0, 600 x 448, origin 0, rotation 0.
// Out-of-range pixels and mode 3 drop out at the mapping stage with no strobe.
// ----------------------------------------------------------------------------
// Panel pixel pack addresser
// Maps a pixel through origin, bounds and panel mode to a masked byte write.
// ----------------------------------------------------------------------------
`include "panel_pixel_pack_addresser_top_assert.svh"

module panel_pixel_pack_addresser_top #(
    parameter int unsigned MAX_SIDE = ppa_pkg::MAX_SIDE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // pixel command
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [ppa_pkg::PIX_W-1:0]           i_pixel_x,
    input  logic [ppa_pkg::PIX_W-1:0]           i_pixel_y,
    input  logic [ppa_pkg::COLOUR_W-1:0]        i_colour,
    // register write port
    input  logic                                i_cfg_we,
    input  logic [ppa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ppa_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // result, one strobe per transfer
    output logic                                o_valid,
    output logic [ppa_pkg::ADDR_W-1:0]          o_byte_address,
    output logic [ppa_pkg::BYTE_W-1:0]          o_bit_mask,
    output logic [ppa_pkg::BYTE_W-1:0]          o_plane0_data,
    output logic                                o_plane1_write,
    output logic [ppa_pkg::BYTE_W-1:0]          o_plane1_data
);

    // Compare width wide enough for both the register and the clamp limit
    localparam int unsigned LIM_W = ($clog2(MAX_SIDE + 1) > ppa_pkg::SIDE_W) ?
                                    $clog2(MAX_SIDE + 1) : ppa_pkg::SIDE_W;
    localparam logic [LIM_W-1:0] SIDE_LIM = LIM_W'(MAX_SIDE);
    localparam int unsigned CW = ppa_pkg::CALC_W;
    localparam logic signed [CW-1:0] ONE = CW'(1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]                          r_mode;
    logic [ppa_pkg::SIDE_W-1:0]          r_width;
    logic [ppa_pkg::SIDE_W-1:0]          r_height;
    logic signed [ppa_pkg::SIDE_W-1:0]   r_origin_x;
    logic signed [ppa_pkg::SIDE_W-1:0]   r_origin_y;
    logic [1:0]                          r_rotation;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= ppa_pkg::MODE_FLIP;
            r_width    <= ppa_pkg::RST_WIDTH;
            r_height   <= ppa_pkg::RST_HEIGHT;
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_rotation <= ppa_pkg::ROT_0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ppa_pkg::REG_MODE:     r_mode     <= i_cfg_data[1:0];
                ppa_pkg::REG_WIDTH:    r_width    <= i_cfg_data;
                ppa_pkg::REG_HEIGHT:   r_height   <= i_cfg_data;
                ppa_pkg::REG_ORIGIN_X: r_origin_x <= $signed(i_cfg_data);
                ppa_pkg::REG_ORIGIN_Y: r_origin_y <= $signed(i_cfg_data);
                ppa_pkg::REG_ROTATION: r_rotation <= i_cfg_data[1:0];
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    // Oversize sides are clamped to the panel limit
    logic [ppa_pkg::SIDE_W-1:0] w_eff;
    logic [ppa_pkg::SIDE_W-1:0] h_eff;

    assign w_eff = (LIM_W'(r_width) > SIDE_LIM) ? ppa_pkg::SIDE_W'(MAX_SIDE) : r_width;
    assign h_eff = (LIM_W'(r_height) > SIDE_LIM) ? ppa_pkg::SIDE_W'(MAX_SIDE) : r_height;

    // The pipeline never stalls: the receiver cannot refuse a transfer.
    assign o_busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: logical position = origin + pixel
    // ------------------------------------------------------------------
    logic                                 r_s1_vld;
    logic signed [ppa_pkg::COORD_W-1:0]   r_s1_lx;
    logic signed [ppa_pkg::COORD_W-1:0]   r_s1_ly;
    logic [ppa_pkg::COLOUR_W-1:0]         r_s1_colour;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_start && !o_busy;
        end
        r_s1_lx     <= ppa_pkg::COORD_W'(r_origin_x) + $signed({2'b00, i_pixel_x});
        r_s1_ly     <= ppa_pkg::COORD_W'(r_origin_y) + $signed({2'b00, i_pixel_y});
        r_s1_colour <= i_colour;
    end

    // ------------------------------------------------------------------
    // Stage 2: bounds check and physical mapping
    // ------------------------------------------------------------------
    logic signed [CW-1:0] lx;
    logic signed [CW-1:0] ly;
    logic signed [CW-1:0] ws;
    logic signed [CW-1:0] hs;
    logic signed [CW-1:0] lw;
    logic signed [CW-1:0] lh;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic                 in_range;
    logic                 planes;
    logic [ppa_pkg::SIDE_W-1:0] px_u;
    ppa_pkg::t_map        n_s2;
    ppa_pkg::t_map        r_s2;

    assign lx = CW'(r_s1_lx);
    assign ly = CW'(r_s1_ly);
    assign ws = $signed({{(CW-ppa_pkg::SIDE_W){1'b0}}, w_eff});
    assign hs = $signed({{(CW-ppa_pkg::SIDE_W){1'b0}}, h_eff});
    // bitplane mode swaps the logical sides on odd rotations
    assign lw = r_rotation[0] ? hs : ws;
    assign lh = r_rotation[0] ? ws : hs;

    always_comb begin
        px       = '0;
        py       = '0;
        in_range = 1'b0;
        planes   = 1'b0;
        unique case (r_mode)
            ppa_pkg::MODE_FLIP: begin
                px       = ws - ONE - lx;
                py       = hs - ONE - ly;
                in_range = (lx >= 0) && (ly >= 0) && (lx < ws) && (ly < hs);
            end
            ppa_pkg::MODE_QUARTER: begin
                px       = ly;
                py       = ws - ONE - lx;
                in_range = (px >= 0) && (px < ws) && (py >= 0) && (py < hs);
            end
            ppa_pkg::MODE_PLANES: begin
                planes   = 1'b1;
                in_range = (lx >= 0) && (ly >= 0) && (lx < lw) && (ly < lh);
                unique case (r_rotation)
                    ppa_pkg::ROT_0: begin
                        px = lw - ONE - lx;
                        py = lh - ONE - ly;
                    end
                    ppa_pkg::ROT_90: begin
                        px = lh - ONE - ly;
                        py = lx;
                    end
                    ppa_pkg::ROT_180: begin
                        px = lx;
                        py = ly;
                    end
                    default: begin
                        px = ly;
                        py = lw - ONE - lx;
                    end
                endcase
            end
            default: ;  // mode 3: nothing is written
        endcase
    end

    // In range, px and py both sit below 2^13, so the low bits are exact.
    assign px_u = px[ppa_pkg::SIDE_W-1:0];

    always_comb begin
        n_s2.valid  = r_s1_vld && in_range;
        n_s2.planes = planes;
        n_s2.py     = py[ppa_pkg::SIDE_W-1:0];
        n_s2.colour = r_s1_colour;
        if (planes) begin
            n_s2.pitch = ppa_pkg::PITCH_W'(w_eff >> 3);
            n_s2.col   = ppa_pkg::PITCH_W'(px_u >> 3);
            n_s2.sub   = px_u[2:0];
        end else begin
            n_s2.pitch = ppa_pkg::PITCH_W'(w_eff >> 1);
            n_s2.col   = ppa_pkg::PITCH_W'(px_u >> 1);
            n_s2.sub   = {{(ppa_pkg::SUB_W-1){1'b0}}, px_u[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2.valid <= n_s2.valid;
        end
        r_s2.planes <= n_s2.planes;
        r_s2.py     <= n_s2.py;
        r_s2.pitch  <= n_s2.pitch;
        r_s2.col    <= n_s2.col;
        r_s2.sub    <= n_s2.sub;
        r_s2.colour <= n_s2.colour;
    end

    // ------------------------------------------------------------------
    // Stages 3 and 4: row multiply, column add, mask and data
    // ------------------------------------------------------------------
    ppa_addr_calc u_addr_calc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_map          (r_s2),
        .o_valid        (o_valid),
        .o_byte_address (o_byte_address),
        .o_bit_mask     (o_bit_mask),
        .o_plane0_data  (o_plane0_data),
        .o_plane1_write (o_plane1_write),
        .o_plane1_data  (o_plane1_data)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a strobe only ever follows an accepted pixel, carried through the register stages
    `PPA_ASSERT_NOW(a_strobe_has_cause, o_valid, $past(i_start, 4))
    // second plane written only in bitplane mode
    `PPA_ASSERT_NOW(a_p1w_mode, o_valid && o_plane1_write, r_mode == ppa_pkg::MODE_PLANES)
    // nibble writes leave the second plane alone and use a half-byte mask
    `PPA_ASSERT_NOW(a_nibble_mask, o_valid && !o_plane1_write,
        (o_plane1_data == '0) &&
        ((o_bit_mask == ppa_pkg::MASK_HI) || (o_bit_mask == ppa_pkg::MASK_LO)))
    // bitplane writes hit one bit, data inside the mask
    `PPA_ASSERT_NOW(a_plane_mask, o_valid && o_plane1_write,
        $onehot(o_bit_mask) && ((o_plane0_data & ~o_bit_mask) == '0) &&
        ((o_plane1_data & ~o_bit_mask) == '0))
    // a mapped pixel reaches the output through the stage 3 and output registers
    `PPA_ASSERT_NEXT(a_s2_to_s3, r_s2.valid, ##1 o_valid)

endmodule

[rtl/ppa_addr_calc.sv]
// ----------------------------------------------------------------------------
// Pixel pack address calculation
// Row multiply and mask/data formation, then column add; two stages.
// ----------------------------------------------------------------------------
module ppa_addr_calc (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ppa_pkg::t_map                       i_map,
    output logic                                o_valid,
    output logic [ppa_pkg::ADDR_W-1:0]          o_byte_address,
    output logic [ppa_pkg::BYTE_W-1:0]          o_bit_mask,
    output logic [ppa_pkg::BYTE_W-1:0]          o_plane0_data,
    output logic                                o_plane1_write,
    output logic [ppa_pkg::BYTE_W-1:0]          o_plane1_data
);

    localparam int unsigned PROD_W = ppa_pkg::SIDE_W + ppa_pkg::PITCH_W;

    // Stage 3: row product and byte formation
    logic                          r_s3_vld;
    logic [ppa_pkg::ADDR_W-1:0]    r_s3_row;
    logic [ppa_pkg::PITCH_W-1:0]   r_s3_col;
    logic [ppa_pkg::BYTE_W-1:0]    r_s3_mask;
    logic [ppa_pkg::BYTE_W-1:0]    r_s3_d0;
    logic [ppa_pkg::BYTE_W-1:0]    r_s3_d1;
    logic                          r_s3_p1w;

    logic [PROD_W-1:0]             n_prod;
    logic [ppa_pkg::BYTE_W-1:0]    n_mask;
    logic [ppa_pkg::BYTE_W-1:0]    n_d0;
    logic [ppa_pkg::BYTE_W-1:0]    n_d1;

    // Output stage
    logic                          r_out_vld;
    logic [ppa_pkg::ADDR_W-1:0]    r_out_addr;
    logic [ppa_pkg::BYTE_W-1:0]    r_out_mask;
    logic [ppa_pkg::BYTE_W-1:0]    r_out_d0;
    logic [ppa_pkg::BYTE_W-1:0]    r_out_d1;
    logic                          r_out_p1w;

    assign n_prod = PROD_W'(i_map.py) * PROD_W'(i_map.pitch);

    always_comb begin
        if (i_map.planes) begin
            n_mask = ppa_pkg::MASK_MSB >> i_map.sub;
            n_d0   = (i_map.colour == ppa_pkg::COLOUR_BLACK) ? '0 : n_mask;
            n_d1   = (i_map.colour >= ppa_pkg::COLOUR_RED) ? '0 : n_mask;
        end else if (i_map.sub[0]) begin
            n_mask = ppa_pkg::MASK_LO;
            n_d0   = {{(ppa_pkg::BYTE_W-ppa_pkg::COLOUR_W){1'b0}}, i_map.colour};
            n_d1   = '0;
        end else begin
            n_mask = ppa_pkg::MASK_HI;
            n_d0   = {i_map.colour, {(ppa_pkg::BYTE_W-ppa_pkg::COLOUR_W){1'b0}}};
            n_d1   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s3_vld  <= i_map.valid;
            r_out_vld <= r_s3_vld;
        end
        r_s3_row   <= n_prod[ppa_pkg::ADDR_W-1:0];   // modulo 2^23
        r_s3_col   <= i_map.col;
        r_s3_mask  <= n_mask;
        r_s3_d0    <= n_d0;
        r_s3_d1    <= n_d1;
        r_s3_p1w   <= i_map.planes;
        r_out_addr <= r_s3_row + ppa_pkg::ADDR_W'(r_s3_col);
        r_out_mask <= r_s3_mask;
        r_out_d0   <= r_s3_d0;
        r_out_d1   <= r_s3_d1;
        r_out_p1w  <= r_s3_p1w;
    end

    assign o_valid        = r_out_vld;
    assign o_byte_address = r_out_addr;
    assign o_bit_mask     = r_out_mask;
    assign o_plane0_data  = r_out_d0;
    assign o_plane1_write = r_out_p1w;
    assign o_plane1_data  = r_out_d1;

endmodule

[test/panel_pixel_pack_addresser_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel pack addresser testbench
// Streams pixels through every panel mode and rotation under a range of
// panel sizes and origins, predicts each masked byte write in the bench and
// compares it field by field with what the block puts out.
// ----------------------------------------------------------------------------
module panel_pixel_pack_addresser_top_test;
    import ppa_pkg::*;

    // Codes that the package leaves unnamed
    localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 3'd6;  // no register behind it
    localparam logic [1:0]           MODE_SPARE  = 2'd3;  // unused mode, drops every pixel
    localparam logic [1:0]           ROT_270     = 2'd3;

    localparam int PIPE_DEPTH   = 4;      // start to strobe, the block's register stages
    localparam int SETTLE_LIMIT = 20000;  // cycles allowed for one burst to drain

    typedef struct packed {
        logic [PIX_W-1:0]    x;
        logic [PIX_W-1:0]    y;
        logic [COLOUR_W-1:0] colour;
    } pixel_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] mask;
        logic [BYTE_W-1:0] plane0;
        logic              plane1_we;
        logic [BYTE_W-1:0] plane1;
    } byte_write_t;

    // DUT ports; the inputs are known from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_start     = 1'b0;
    logic                  o_busy;
    logic [PIX_W-1:0]      i_pixel_x   = '0;
    logic [PIX_W-1:0]      i_pixel_y   = '0;
    logic [COLOUR_W-1:0]   i_colour    = '0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_valid;
    logic [ADDR_W-1:0]     o_byte_address;
    logic [BYTE_W-1:0]     o_bit_mask;
    logic [BYTE_W-1:0]     o_plane0_data;
    logic                  o_plane1_write;
    logic [BYTE_W-1:0]     o_plane1_data;

    // Bench copy of the panel registers, loaded with the reset values
    logic [1:0]               cfg_mode   = MODE_FLIP;
    logic [SIDE_W-1:0]        cfg_width  = RST_WIDTH;
    logic [SIDE_W-1:0]        cfg_height = RST_HEIGHT;
    logic signed [SIDE_W-1:0] cfg_ox     = '0;
    logic signed [SIDE_W-1:0] cfg_oy     = '0;
    logic [1:0]               cfg_rot    = ROT_0;

    pixel_t      pending_pixels[$];   // waiting for the driver
    byte_write_t expected_writes[$];  // predicted, not yet seen on the outputs
    int          gap_left      = 0;
    bit          gaps_on       = 1'b1;
    int          mismatch_count = 0;

    panel_pixel_pack_addresser_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_colour       (i_colour),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_byte_address (o_byte_address),
        .o_bit_mask     (o_bit_mask),
        .o_plane0_data  (o_plane0_data),
        .o_plane1_write (o_plane1_write),
        .o_plane1_data  (o_plane1_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or drops strobes
    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction: origin offset, bounds check and mode mapping of one pixel.
    // Returns 0 where the pixel falls off the panel (or the mode is unused).
    // ------------------------------------------------------------------------
    function automatic bit map_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                                     input logic [COLOUR_W-1:0] colour,
                                     output byte_write_t wr);
        int w, h, lx, ly, lw, lh, px, py, addr;
        wr = '0;
        // sides above the maximum are clamped
        w  = (cfg_width  > MAX_SIDE_DEF) ? MAX_SIDE_DEF : int'(cfg_width);
        h  = (cfg_height > MAX_SIDE_DEF) ? MAX_SIDE_DEF : int'(cfg_height);
        lx = int'(cfg_ox) + int'(x);
        ly = int'(cfg_oy) + int'(y);
        case (cfg_mode)
            MODE_FLIP, MODE_QUARTER: begin
                if (cfg_mode == MODE_FLIP) begin
                    if (lx < 0 || ly < 0 || lx >= w || ly >= h)
                        return 1'b0;
                    px = w - 1 - lx;
                    py = h - 1 - ly;
                end else begin
                    px = ly;
                    py = w - 1 - lx;
                    if (px < 0 || px >= w || py < 0 || py >= h)
                        return 1'b0;
                end
                // two pixels per byte, even column in the high nibble
                addr = py * (w / 2) + px / 2;
                wr.mask   = px[0] ? MASK_LO : MASK_HI;
                wr.plane0 = px[0] ? {4'h0, colour} : {colour, 4'h0};
            end
            MODE_PLANES: begin
                lw = cfg_rot[0] ? h : w;
                lh = cfg_rot[0] ? w : h;
                if (lx < 0 || ly < 0 || lx >= lw || ly >= lh)
                    return 1'b0;
                case (cfg_rot)
                    ROT_0: begin
                        px = lw - 1 - lx;
                        py = lh - 1 - ly;
                    end
                    ROT_90: begin
                        px = lh - 1 - ly;
                        py = lx;
                    end
                    ROT_180: begin
                        px = lx;
                        py = ly;
                    end
                    default: begin
                        px = ly;
                        py = lw - 1 - lx;
                    end
                endcase
                // eight pixels per byte, MSB first; black clears plane 0, red plane 1
                addr = (w / 8) * py + px / 8;
                wr.mask      = MASK_MSB >> px[2:0];
                wr.plane0    = (colour == COLOUR_BLACK) ? '0 : wr.mask;
                wr.plane1    = (colour >= COLOUR_RED)   ? '0 : wr.mask;
                wr.plane1_we = 1'b1;
            end
            default: return 1'b0;
        endcase
        wr.addr = addr[ADDR_W-1:0];
        return 1'b1;
    endfunction

    // Gap after a transfer: mostly none, some short, a few long
    function automatic int next_gap();
        int pick;
        if (!gaps_on)
            return 0;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return 0;
        if (pick < 9)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents pending pixels on the command port. A pixel transfers
    // at an edge with start high and busy low; the prediction is made there.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_pixels
        pixel_t      pix;
        byte_write_t wr;
        if (!i_rst_n) begin
            i_start  <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_start && !o_busy) begin
                if (map_pixel(i_pixel_x, i_pixel_y, i_colour, wr))
                    expected_writes.push_back(wr);
            end
            if (i_start && o_busy) begin
                // refused, hold the pixel
            end else if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                i_start  <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
                pix = pending_pixels.pop_front();
                i_pixel_x <= pix.x;
                i_pixel_y <= pix.y;
                i_colour  <= pix.colour;
                i_start   <= 1'b1;
                gap_left  <= next_gap();
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    task automatic compare_field(input string name, input logic [ADDR_W-1:0] want,
                                 input logic [ADDR_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: every strobe is one byte-write transfer, checked against the
    // oldest prediction. The block cannot be held off, so there is no stall.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_writes
        byte_write_t want;
        if (i_rst_n && o_valid) begin
            if (expected_writes.size() == 0) begin
                $error("byte write with none expected: address %0h", o_byte_address);
                mismatch_count++;
            end else begin
                want = expected_writes.pop_front();
                compare_field("byte_address", want.addr,      o_byte_address);
                compare_field("bit_mask",     want.mask,      o_bit_mask);
                compare_field("plane0_data",  want.plane0,    o_plane0_data);
                compare_field("plane1_write", want.plane1_we, o_plane1_write);
                compare_field("plane1_data",  want.plane1,    o_plane1_data);
            end
        end
    end

    // Register write: one cycle of enable, bench copy follows the register
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_MODE:     cfg_mode   = value[1:0];
            REG_WIDTH:    cfg_width  = value;
            REG_HEIGHT:   cfg_height = value;
            REG_ORIGIN_X: cfg_ox     = value;
            REG_ORIGIN_Y: cfg_oy     = value;
            REG_ROTATION: cfg_rot    = value[1:0];
            default: ;
        endcase
    endtask

    task automatic set_panel(input logic [1:0] mode, input int w, input int h,
                             input int ox, input int oy, input logic [1:0] rot);
        write_reg(REG_MODE,     CFG_DATA_W'(mode));
        write_reg(REG_WIDTH,    CFG_DATA_W'(w));
        write_reg(REG_HEIGHT,   CFG_DATA_W'(h));
        write_reg(REG_ORIGIN_X, CFG_DATA_W'(ox));
        write_reg(REG_ORIGIN_Y, CFG_DATA_W'(oy));
        write_reg(REG_ROTATION, CFG_DATA_W'(rot));
    endtask

    task automatic push_pixel(input int x, input int y, input int colour);
        pending_pixels.push_back('{x: PIX_W'(x), y: PIX_W'(y), colour: COLOUR_W'(colour)});
    endtask

    // Wait for all transfers to go and every expected write to come back,
    // then let the pipe empty of pixels that produce nothing.
    task automatic settle();
        int waited;
        waited = 0;
        while ((pending_pixels.size() != 0 || i_start || expected_writes.size() != 0)
               && waited < SETTLE_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);
        if (expected_writes.size() != 0) begin
            $error("%0d expected byte writes never arrived", expected_writes.size());
            mismatch_count++;
            expected_writes.delete();
        end
    endtask

    // Coordinate aimed at the logical window [lo,hi] after the origin shift;
    // now and then just outside it, or anywhere at all.
    function automatic int pick_coord(input int lo, input int hi, input int org);
        int a, b, pick;
        a    = lo - org;
        b    = hi - org;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return $urandom_range(0, 4095);
        if (pick == 1) begin
            a = b + 1;
            b = a;
        end else if (pick == 2) begin
            a = a - 1;
            b = a;
        end
        if (a < 0)
            a = 0;
        if (b > 4095)
            b = 4095;
        if (a > b)
            return $urandom_range(0, 4095);
        return $urandom_range(unsigned'(b), unsigned'(a));
    endfunction

    // Burst of pixels shaped to land mostly on the current panel
    task automatic random_burst(input int count);
        int w, h, xlo, xhi, ylo, yhi, colour;
        w = (cfg_width  > MAX_SIDE_DEF) ? MAX_SIDE_DEF : int'(cfg_width);
        h = (cfg_height > MAX_SIDE_DEF) ? MAX_SIDE_DEF : int'(cfg_height);
        xlo = 0;
        ylo = 0;
        xhi = w - 1;
        yhi = h - 1;
        if (cfg_mode == MODE_QUARTER) begin
            xlo = w - h;
            yhi = w - 1;
        end else if (cfg_mode == MODE_PLANES && cfg_rot[0]) begin
            xhi = h - 1;
            yhi = w - 1;
        end
        gaps_on = ($urandom_range(0, 3) != 0);
        repeat (count) begin
            // bitplane colours are white, black and red; the rest is noise
            colour = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
            push_pixel(pick_coord(xlo, xhi, int'(cfg_ox)), pick_coord(ylo, yhi, int'(cfg_oy)),
                       colour);
        end
        settle();
    endtask

    function automatic int rand_side(input bit is_width);
        case ($urandom_range(0, 5))
            0: return is_width ? 8 * $urandom_range(1, 512) : $urandom_range(1, 4096);
            1: return is_width ? 2 * $urandom_range(4, 2048) : $urandom_range(1, 4096);
            2: return is_width ? $urandom_range(8, 4096) : $urandom_range(1, 4096);
            3: return is_width ? $urandom_range(8, 64) : $urandom_range(1, 64);
            4: return $urandom_range(4097, 8191);  // oversize, clamped
            default: return MAX_SIDE_DEF;
        endcase
    endfunction

    function automatic int rand_origin();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return int'($urandom_range(0, 128)) - 64;
            2: return int'($urandom_range(0, 8191)) - 4096;
            default: return -int'($urandom_range(0, 200));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Sequence: directed corners of each mode, extreme settings, then random
    // panels. Registers only change once the pipe is empty.
    // ------------------------------------------------------------------------
    initial begin : run_sequence
        int          phase;
        logic [1:0]  mode;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // write to an index with no register behind it: must change nothing
        write_reg(REG_SPARE, '1);

        // reset settings, 180-degree nibble flip: corners and just off them
        push_pixel(0, 0, 0);
        push_pixel(599, 447, 15);
        push_pixel(600, 0, 3);
        push_pixel(0, 448, 3);
        push_pixel(4095, 4095, 9);
        push_pixel(1, 0, 10);
        settle();

        // quarter turn: rows come from x, columns from y
        set_panel(MODE_QUARTER, 600, 448, 0, 0, ROT_0);
        push_pixel(152, 0, 7);
        push_pixel(599, 599, 8);
        push_pixel(599, 600, 2);
        push_pixel(151, 0, 2);
        settle();

        // bitplanes, each rotation with two pixels; white, black and red all appear
        set_panel(MODE_PLANES, 16, 8, 0, 0, ROT_0);
        push_pixel(0, 0, 0);
        push_pixel(15, 7, 1);
        settle();
        set_panel(MODE_PLANES, 16, 8, 0, 0, ROT_90);
        push_pixel(7, 15, 2);
        push_pixel(0, 0, 15);
        settle();
        set_panel(MODE_PLANES, 16, 8, 0, 0, ROT_180);
        push_pixel(0, 0, 1);
        push_pixel(15, 7, 0);
        settle();
        set_panel(MODE_PLANES, 16, 8, 0, 0, ROT_270);
        push_pixel(7, 15, 1);
        push_pixel(8, 0, 2);
        settle();

        // unused mode and zero width: nothing comes out
        set_panel(MODE_SPARE, 600, 448, 0, 0, ROT_0);
        push_pixel(0, 0, 1);
        settle();
        set_panel(MODE_FLIP, 0, 448, 0, 0, ROT_0);
        push_pixel(0, 0, 3);
        settle();

        // oversize sides are clamped to the maximum
        set_panel(MODE_FLIP, 8191, 8191, 0, 0, ROT_0);
        push_pixel(4095, 4095, 15);
        push_pixel(0, 0, 6);
        settle();

        // extreme settings
        set_panel(MODE_FLIP, MAX_SIDE_DEF, MAX_SIDE_DEF, 0, 0, ROT_0);
        random_burst(60);
        set_panel(MODE_PLANES, 8191, 8191, 4095, 4095, ROT_270);
        random_burst(20);
        set_panel(MODE_QUARTER, 8, 1, -4096, -4096, ROT_90);
        random_burst(20);
        set_panel(MODE_PLANES, 8, 1, 0, 0, ROT_90);
        random_burst(30);
        set_panel(MODE_PLANES, MAX_SIDE_DEF, MAX_SIDE_DEF, 0, 0, ROT_180);
        random_burst(40);
        set_panel(MODE_SPARE, 600, 448, 0, 0, ROT_270);
        random_burst(10);

        // random panels, bitplane mode a little more often
        for (phase = 0; phase < 13; phase++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: mode = MODE_FLIP;
                3, 4, 5: mode = MODE_QUARTER;
                default: mode = MODE_PLANES;
            endcase
            set_panel(mode, rand_side(1'b1), rand_side(1'b0), rand_origin(), rand_origin(),
                      2'($urandom_range(0, 3)));
            random_burst(50);
        end

        settle();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/ppa_pkg.sv
rtl/ppa_addr_calc.sv
rtl/panel_pixel_pack_addresser_top.sv
test/panel_pixel_pack_addresser_top_test.sv
